[design/sgm_pkg.sv]
// shared types and constants for the sobel gradient magnitude block
`default_nettype none
package sgm_pkg;
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_SQ   = 5'b00100,
        S_SQRT = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam int PIX_W   = 24;
    localparam int GRAD_W  = 11;
    localparam int SUM_W   = 22;
    localparam int ROOT_W  = 11;
    localparam int REM_W   = 14;
    localparam int SQ_STEPS = 11;
endpackage
`default_nettype wire

[design/sgm_ram.sv]
// generic simple dual port ram with registered read
`default_nettype none
module sgm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[design/sobel_gradient_magnitude_3x3_top.sv]
// top level of the streaming 3x3 sobel gradient and magnitude block
//
// channel   dir  handshake                tdata / tuser
// s_axis    in   s_axis_tvalid/tready     tdata: chan0, chan1, chan2
// m_axis    out  m_axis_tvalid/tready     tdata: gx0..2, gy0..2, mag0..2; tlast row_end;
//                                         tuser frame_end
// cfg       in   i_cfg_we                 i_cfg_addr, i_cfg_wdata
//
// each pixel passes the accept state and a line buffer read; a pixel without a result then
// returns to idle, a border result goes to the output load, and an interior result first
// takes a squaring step and the bit-serial square root. a new pixel is accepted only in
// idle. reset clears counters, window and the output valid flag; line buffers are not
// cleared. a stalled output only holds the block once a new result is ready to load.
`default_nettype none
module sobel_gradient_magnitude_3x3_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [23:0]  s_axis_tdata,   // chan0, chan1, chan2
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // gx0, gx1, gx2, gy0, gy1, gy2, mag0, mag1, mag2, zeros
    output logic         m_axis_tlast,
    output logic         m_axis_tuser,   // frame_end
    input  wire          i_cfg_we,
    input  wire          i_cfg_addr,
    input  wire  [15:0]  i_cfg_wdata
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int GW = sgm_pkg::GRAD_W;

    sgm_pkg::t_state r_state;
    logic [10:0] r_iw;
    logic [15:0] r_ih;
    logic [CW-1:0] r_col, r_c;
    logic [15:0] r_row, r_r;
    logic [23:0] r_cur;
    logic [23:0] r_win [6];
    logic r_int, r_rowend, r_frmend;
    logic signed [GW-1:0] r_gx [3];
    logic signed [GW-1:0] r_gy [3];
    logic [sgm_pkg::SUM_W-1:0]  r_s    [3];
    logic [sgm_pkg::ROOT_W-1:0] r_root [3];
    logic [sgm_pkg::REM_W-1:0]  r_rem  [3];
    logic [3:0] r_it;
    logic r_ov;
    logic [95:0] r_od;
    logic r_ol, r_ou;

    logic [31:0] w_eff;
    logic [CW-1:0] w_last;
    logic [15:0] h_last;
    logic [CW-1:0] c_clamp, raddr;
    logic [15:0] r_clamp;
    logic [23:0] up, lo;
    logic in_acc, out_free;
    logic signed [GW-1:0] n_gx [3];
    logic signed [GW-1:0] n_gy [3];
    logic [sgm_pkg::SUM_W-1:0] n_sq [3];
    logic [sgm_pkg::REM_W-1:0] n_rem [3];
    logic [sgm_pkg::REM_W-1:0] trial [3];
    logic [7:0] mag [3];
    logic [sgm_pkg::ROOT_W:0] rnd [3];

    always_comb begin
        w_eff = (32'(r_iw) < 32'd3) ? 32'd3 :
                (32'(r_iw) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(r_iw);
        w_last = CW'(w_eff - 32'd1);
        h_last = (r_ih < 16'd3) ? 16'd2 : r_ih - 16'd1;
        c_clamp = (r_col > w_last) ? w_last : r_col;
        r_clamp = (r_row > h_last) ? h_last : r_row;
        raddr = c_clamp;
    end

    assign s_axis_tready = (r_state == sgm_pkg::S_IDLE);
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ov || m_axis_tready;

    sgm_ram #(.WIDTH(sgm_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk(i_clk), .i_we(r_state == sgm_pkg::S_READ), .i_waddr(r_c),
        .i_wdata(lo), .i_raddr(raddr), .o_rdata(up));
    sgm_ram #(.WIDTH(sgm_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
        .i_clk(i_clk), .i_we(r_state == sgm_pkg::S_READ), .i_waddr(r_c),
        .i_wdata(r_cur), .i_raddr(raddr), .o_rdata(lo));

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic signed [GW-1:0] tl, ml, bl, tm, bm, tr, mr, br;
            logic signed [sgm_pkg::SUM_W-1:0] gxe, gye;
            tl = $signed({3'b0, r_win[3][8*k +: 8]});
            ml = $signed({3'b0, r_win[4][8*k +: 8]});
            bl = $signed({3'b0, r_win[5][8*k +: 8]});
            tm = $signed({3'b0, r_win[0][8*k +: 8]});
            bm = $signed({3'b0, r_win[2][8*k +: 8]});
            tr = $signed({3'b0, up[8*k +: 8]});
            mr = $signed({3'b0, lo[8*k +: 8]});
            br = $signed({3'b0, r_cur[8*k +: 8]});
            n_gx[k] = (tr - tl) + ((mr - ml) <<< 1) + (br - bl);
            n_gy[k] = (bl + (bm <<< 1) + br) - (tl + (tm <<< 1) + tr);
            gxe = {{(sgm_pkg::SUM_W-GW){r_gx[k][GW-1]}}, r_gx[k]};
            gye = {{(sgm_pkg::SUM_W-GW){r_gy[k][GW-1]}}, r_gy[k]};
            n_sq[k] = $unsigned(gxe * gxe + gye * gye);
            n_rem[k] = {r_rem[k][sgm_pkg::REM_W-3:0],
                        r_s[k][sgm_pkg::SUM_W-1 -: 2]};
            trial[k] = {1'b0, r_root[k], 2'b01};
            rnd[k] = {1'b0, r_root[k]} +
                     {{sgm_pkg::ROOT_W{1'b0}},
                      (r_rem[k] > {{(sgm_pkg::REM_W-sgm_pkg::ROOT_W){1'b0}}, r_root[k]})};
            mag[k] = (rnd[k] > 12'd255) ? 8'd255 : rnd[k][7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sgm_pkg::S_IDLE;
            r_iw <= 11'd640;
            r_ih <= 16'd480;
            r_col <= '0;
            r_row <= '0;
            r_ov <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    sgm_pkg::REG_WIDTH:  r_iw <= i_cfg_wdata[10:0];
                    sgm_pkg::REG_HEIGHT: r_ih <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (r_ov && m_axis_tready && (r_state != sgm_pkg::S_OUT)) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                sgm_pkg::S_IDLE: begin
                    if (in_acc) begin
                        r_c <= c_clamp;
                        r_r <= r_clamp;
                        r_cur <= s_axis_tdata;
                        r_state <= sgm_pkg::S_READ;
                    end
                end
                sgm_pkg::S_READ: begin
                    r_win[3] <= r_win[0];
                    r_win[4] <= r_win[1];
                    r_win[5] <= r_win[2];
                    r_win[0] <= up;
                    r_win[1] <= lo;
                    r_win[2] <= r_cur;
                    r_int <= (r_r >= 16'd2) && (r_c >= CW'(2));
                    r_rowend <= (r_c == w_last);
                    r_frmend <= (r_c == w_last) && (r_r == h_last);
                    for (int k = 0; k < 3; k++) begin
                        r_gx[k] <= n_gx[k];
                        r_gy[k] <= n_gy[k];
                    end
                    if (r_c >= w_last) begin
                        r_col <= '0;
                        r_row <= (r_r >= h_last) ? 16'd0 : r_r + 16'd1;
                    end else begin
                        r_col <= r_c + CW'(1);
                    end
                    if ((r_r >= 16'd2) && (r_c >= CW'(2))) begin
                        r_state <= sgm_pkg::S_SQ;
                    end else if ((r_r >= 16'd1) && (r_c >= CW'(1))) begin
                        r_state <= sgm_pkg::S_OUT;
                    end else begin
                        r_state <= sgm_pkg::S_IDLE;
                    end
                end
                sgm_pkg::S_SQ: begin
                    for (int k = 0; k < 3; k++) begin
                        r_s[k] <= n_sq[k];
                        r_root[k] <= '0;
                        r_rem[k] <= '0;
                    end
                    r_it <= '0;
                    r_state <= sgm_pkg::S_SQRT;
                end
                sgm_pkg::S_SQRT: begin
                    for (int k = 0; k < 3; k++) begin
                        r_s[k] <= r_s[k] << 2;
                        if (n_rem[k] >= trial[k]) begin
                            r_rem[k] <= n_rem[k] - trial[k];
                            r_root[k] <= {r_root[k][sgm_pkg::ROOT_W-2:0], 1'b1};
                        end else begin
                            r_rem[k] <= n_rem[k];
                            r_root[k] <= {r_root[k][sgm_pkg::ROOT_W-2:0], 1'b0};
                        end
                    end
                    r_it <= r_it + 4'd1;
                    if (r_it == 4'(sgm_pkg::SQ_STEPS - 1)) begin
                        r_state <= sgm_pkg::S_OUT;
                    end
                end
                sgm_pkg::S_OUT: begin
                    if (out_free) begin
                        r_ov <= 1'b1;
                        r_ol <= r_rowend;
                        r_ou <= r_frmend;
                        if (r_int) begin
                            r_od <= {6'b0, mag[2], mag[1], mag[0],
                                     r_gy[2], r_gy[1], r_gy[0],
                                     r_gx[2], r_gx[1], r_gx[0]};
                        end else begin
                            r_od <= '0;
                        end
                        r_state <= sgm_pkg::S_IDLE;
                    end
                end
                default: r_state <= sgm_pkg::S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = r_od;
    assign m_axis_tlast = r_ol;
    assign m_axis_tuser = r_ou;

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == sgm_pkg::S_READ)
        else $error("accepted pixel did not go to line buffer read");
    a_load_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == sgm_pkg::S_OUT))
        else $error("result loaded outside output state");
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sgm_pkg::S_READ |-> r_c <= w_last)
        else $error("column position beyond row end");
    a_sqrt_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sgm_pkg::S_SQRT |-> r_it < 4'(sgm_pkg::SQ_STEPS))
        else $error("square root step count overrun");
endmodule
`default_nettype wire

[tb/sobel_gradient_magnitude_3x3_top_tb.sv]
// self-checking testbench for the streaming 3x3 sobel gradient and magnitude block
`default_nettype none
module sobel_gradient_magnitude_3x3_top_tb;
    localparam int MAX_W_TB = 1024;

    typedef struct packed {
        logic [sgm_pkg::GRAD_W-1:0] gx0, gx1, gx2, gy0, gy1, gy2;
        logic [7:0]        mag0, mag1, mag2;
        logic              row_end, frame_end;
    } t_grad;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    wire          s_axis_tready;
    logic [23:0]  s_axis_tdata = '0;
    wire          m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    wire  [95:0]  m_axis_tdata;
    wire          m_axis_tlast;
    wire          m_axis_tuser;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_addr = sgm_pkg::REG_WIDTH;
    logic [15:0]  i_cfg_wdata = '0;

    sobel_gradient_magnitude_3x3_top u_top (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic [10:0] cfg_w;
    logic [15:0] cfg_h;
    logic [23:0] line_up [MAX_W_TB];
    logic [23:0] line_lo [MAX_W_TB];
    logic [23:0] win [6];
    int unsigned col_cnt, row_cnt;

    t_grad grad_queue [$];
    int    errors = 0;
    int    send_idle = 0, recv_idle = 0;
    int    hold_left = 0;

    function automatic int unsigned round_root(int unsigned s);
        int unsigned n = 0;
        while ((n + 1) * (n + 1) <= s) n++;
        if (s - n * n > n) n++;
        return (n > 255) ? 255 : n;
    endfunction

    function automatic int pch(logic [23:0] p, int k);
        return int'(p[8*k +: 8]);
    endfunction

    task automatic predict_pixel(input logic [23:0] cur);
        int unsigned w, h, c, r;
        logic [23:0] up, lo;
        int gx [3], gy [3];
        int unsigned m [3];
        t_grad g;
        w = cfg_w; h = cfg_h;
        if (w < 3) w = 3;
        if (w > MAX_W_TB) w = MAX_W_TB;
        if (h < 3) h = 3;
        if (col_cnt > w - 1) col_cnt = w - 1;
        if (row_cnt > h - 1) row_cnt = h - 1;
        c = col_cnt; r = row_cnt;
        up = line_up[c]; lo = line_lo[c];
        if (r >= 1 && c >= 1) begin
            for (int k = 0; k < 3; k++) begin
                gx[k] = 0; gy[k] = 0; m[k] = 0;
                if (r >= 2 && c >= 2) begin
                    gx[k] = (pch(up, k) - pch(win[3], k)) + 2 * (pch(lo, k) - pch(win[4], k))
                          + (pch(cur, k) - pch(win[5], k));
                    gy[k] = (pch(win[5], k) + 2 * pch(win[2], k) + pch(cur, k))
                          - (pch(win[3], k) + 2 * pch(win[0], k) + pch(up, k));
                    m[k] = round_root(gx[k] * gx[k] + gy[k] * gy[k]);
                end
            end
            g.gx0 = gx[0][10:0]; g.gx1 = gx[1][10:0]; g.gx2 = gx[2][10:0];
            g.gy0 = gy[0][10:0]; g.gy1 = gy[1][10:0]; g.gy2 = gy[2][10:0];
            g.mag0 = m[0][7:0]; g.mag1 = m[1][7:0]; g.mag2 = m[2][7:0];
            g.row_end = (c == w - 1);
            g.frame_end = (c == w - 1) && (r == h - 1);
            grad_queue.push_back(g);
        end
        win[3] = win[0]; win[4] = win[1]; win[5] = win[2];
        win[0] = up; win[1] = lo; win[2] = cur;
        line_up[c] = lo; line_lo[c] = cur;
        if (c >= w - 1) begin
            col_cnt = 0;
            row_cnt = (r >= h - 1) ? 0 : r + 1;
        end else begin
            col_cnt = c + 1;
        end
    endtask

    // output checking
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_grad a, e;
            a.gx0 = m_axis_tdata[10:0];  a.gx1 = m_axis_tdata[21:11];
            a.gx2 = m_axis_tdata[32:22]; a.gy0 = m_axis_tdata[43:33];
            a.gy1 = m_axis_tdata[54:44]; a.gy2 = m_axis_tdata[65:55];
            a.mag0 = m_axis_tdata[73:66]; a.mag1 = m_axis_tdata[81:74];
            a.mag2 = m_axis_tdata[89:82];
            a.row_end = m_axis_tlast; a.frame_end = m_axis_tuser;
            if (grad_queue.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, actual %h", $time, a);
                errors++;
            end else begin
                e = grad_queue.pop_front();
                if (a !== e || m_axis_tdata[95:90] !== '0) begin
                    $display("%0t: mismatch expected %h actual %h (tdata %h)",
                             $time, e, a, m_axis_tdata);
                    errors++;
                end
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic cfg_write(input logic addr, input logic [15:0] val);
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_addr <= addr; i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == sgm_pkg::REG_WIDTH) cfg_w = val[10:0];
        else cfg_h = val;
    endtask

    task automatic send_pixel(input logic [23:0] px);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_pixel(px);
        @(negedge i_clk);
    endtask

    task automatic drain;
        int guard = 0;
        s_axis_tvalid <= 1'b0;
        while (grad_queue.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (40) @(negedge i_clk);
    endtask

    function automatic logic [23:0] rand_px(int mode);
        case (mode)
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            2: return ($urandom_range(1)) ? 24'hFFFFFF : 24'h000000;
            default: return 24'($urandom());
        endcase
    endfunction

    // directed rows: extremes and mixes, checked against the predictor
    logic [23:0] dir_table [25] = '{
        24'h000000, 24'h000000, 24'h000000, 24'h000000,
        24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
        24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
        24'hFF00FF, 24'h00FF00, 24'hFFFFFF, 24'h000000,
        24'h123456, 24'hA5A5A5, 24'h5A5A5A, 24'h808080,
        24'h7F7F7F, 24'h010203, 24'hFEFDFC, 24'hFFFFFF, 24'h000000
    };

    int widths [5]  = '{3, 4, 7, 16, 2};
    int heights [5] = '{3, 5, 4, 6, 65535};

    initial begin
        int mode;
        cfg_w = 11'd640; cfg_h = 16'd480;
        for (int i = 0; i < 6; i++) begin win[i] = '0; end
        for (int i = 0; i < MAX_W_TB; i++) begin line_up[i] = '0; line_lo[i] = '0; end
        col_cnt = 0; row_cnt = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: 4 wide, extremes and mixes
        cfg_write(sgm_pkg::REG_WIDTH, 16'd4);
        cfg_write(sgm_pkg::REG_HEIGHT, 16'd3);
        foreach (dir_table[i]) send_pixel(dir_table[i]);
        drain();
        // finish the partial frame so later phases start aligned
        while (col_cnt != 0 || row_cnt != 0) send_pixel(rand_px(3));
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 31 : (ph == 1) ? 61 : 0;
            recv_idle = (ph == 0) ? 61 : (ph == 1) ? 31 : 0;
            for (int s = 0; s < 5; s++) begin
                int n;
                cfg_write(sgm_pkg::REG_WIDTH, 16'(widths[s]));
                cfg_write(sgm_pkg::REG_HEIGHT, 16'(heights[s]));
                if (ph == 2 && s == 0) hold_left = 300;
                n = 40;
                mode = $urandom_range(3);
                for (int i = 0; i < n; i++) begin
                    if (i % 17 == 0) mode = $urandom_range(5);
                    send_pixel(rand_px(mode));
                end
                // complete the frame only where the height is small
                if (heights[s] < 100)
                    while (col_cnt != 0 || row_cnt != 0) send_pixel(rand_px(3));
                drain();
            end
            // leave mid-frame state consistent before next widths
            cfg_write(sgm_pkg::REG_WIDTH, 16'd3);
            cfg_write(sgm_pkg::REG_HEIGHT, 16'd3);
            while (col_cnt != 0 || row_cnt != 0) send_pixel(rand_px(3));
            drain();
        end
        // width above range is clamped, then shrinking the width mid-frame clamps the column
        cfg_write(sgm_pkg::REG_WIDTH, 16'h07FF);
        cfg_write(sgm_pkg::REG_HEIGHT, 16'd0);
        for (int i = 0; i < 1024 + 40; i++) send_pixel(rand_px(3));
        drain();
        cfg_write(sgm_pkg::REG_WIDTH, 16'd3);
        while (col_cnt != 0 || row_cnt != 0) send_pixel(rand_px(3));
        drain();

        if (errors == 0 && grad_queue.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
